### design/bts_pkg.sv
// Shared types and constants for the buzzer tone pattern sequencer.
// No dependencies; every design file but bts_if refers to it by scoped names.
package bts_pkg;

    // Command codes carried by an input transaction
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_FINDER = 2'd2;

    // Pattern numbers
    localparam logic [7:0] PAT_NONE = 8'd0;
    localparam logic [7:0] PAT_1    = 8'd1;
    localparam logic [7:0] PAT_2    = 8'd2;
    localparam logic [7:0] PAT_3    = 8'd3;
    localparam logic [7:0] PAT_4    = 8'd4;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_FINDER_EN   = 3'd0;
    localparam logic [2:0] REG_FAST_END    = 3'd1;
    localparam logic [2:0] REG_MEDIUM_END  = 3'd2;
    localparam logic [2:0] REG_FAST_PER    = 3'd3;
    localparam logic [2:0] REG_MEDIUM_PER  = 3'd4;
    localparam logic [2:0] REG_SLOW_PER    = 3'd5;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register reset values
    localparam logic [31:0] RST_FAST_END   = 32'd60000;
    localparam logic [31:0] RST_MEDIUM_END = 32'd300000;
    localparam logic [15:0] RST_FAST_PER   = 16'd2000;
    localparam logic [15:0] RST_MEDIUM_PER = 16'd3000;
    localparam logic [15:0] RST_SLOW_PER   = 16'd5000;

    localparam logic [10:0] PAT_MS_MAX   = 11'd2047;
    localparam logic [11:0] DEFAULT_TONE = 12'd2400;

    // Remainder unit: one dividend bit per step
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = 6;

    typedef struct packed {
        logic        finder_enable;
        logic [31:0] fast_band_end_ms;
        logic [31:0] medium_band_end_ms;
        logic [15:0] fast_period_ms;
        logic [15:0] medium_period_ms;
        logic [15:0] slow_period_ms;
    } cfg_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // apply the accepted command to the state
        logic div_start;  // load the remainder unit
        logic div_step;   // advance the remainder unit by one bit
        logic eval;       // evaluate and load the result register
    } ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EVAL  = 4'b1000
    } state_t;

endpackage

### design/bts_if.sv
// Channel interfaces of the buzzer tone pattern sequencer: commands in, results out.
// Depends on nothing.
interface bts_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] pattern_number;
    logic       finder_on;

    modport source (output valid, output command, output pattern_number,
                    output finder_on, input ready);
    modport sink   (input valid, input command, input pattern_number,
                    input finder_on, output ready);
endinterface

interface bts_res_if;
    logic        valid;
    logic        ready;
    logic        buzzer_on;
    logic [11:0] tone_hz;

    modport source (output valid, output buzzer_on, output tone_hz, input ready);
    modport sink   (input valid, input buzzer_on, input tone_hz, output ready);
endinterface

### design/bts_ctrl.sv
// Controller state machine of the buzzer tone pattern sequencer.
// Depends on bts_pkg.
module bts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bts_pkg::stat_t stat,
    output bts_pkg::ctrl_t ctl
);

    bts_pkg::state_t state_reg;
    bts_pkg::state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        ctl           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            bts_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = bts_pkg::ST_START;
                end
            end
            bts_pkg::ST_START:
            begin
                ctl.div_start = 1'b1;
                state_next    = bts_pkg::ST_DIV;
            end
            bts_pkg::ST_DIV:
            begin
                if (stat.div_done)
                    state_next = bts_pkg::ST_EVAL;
                else
                    ctl.div_step = 1'b1;
            end
            bts_pkg::ST_EVAL:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    ctl.eval   = 1'b1;
                    state_next = bts_pkg::ST_IDLE;
                end
            end
            default:
                state_next = bts_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bts_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### design/bts_dp.sv
// Datapath of the buzzer tone pattern sequencer: sequencer state, bit-serial
// remainder unit, tone evaluation and result register. Depends on bts_pkg.
module bts_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  bts_pkg::cfg_t  cfg,
    input  bts_pkg::ctrl_t ctl,
    output bts_pkg::stat_t stat,
    input  logic [1:0]     command,
    input  logic [7:0]     pattern_number,
    input  logic           finder_on,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           buzzer_on,
    output logic [11:0]    tone_hz
);

    logic [7:0]  act_pat_reg, act_pat_next;
    logic [10:0] pat_ms_reg, pat_ms_next;
    logic        fin_act_reg, fin_act_next;
    logic [31:0] fin_ms_reg, fin_ms_next;

    logic [31:0]              dvd_reg, dvd_next;
    logic [15:0]              rem_reg, rem_next;
    logic [bts_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_on_reg, out_on_next;
    logic [11:0] out_hz_reg, out_hz_next;

    logic        in_fast, in_medium;
    logic [15:0] period;
    logic [16:0] rem_sh, rem_diff;
    logic        rem_ge;

    logic [31:0] t, ph;
    logic        pat_on, pat_clear, fin_on, eval_on, finder_play;
    logic [11:0] pat_hz, fin_hz, eval_hz;

    function automatic logic win(input logic [31:0] x, input logic [31:0] from,
                                 input logic [31:0] len);
        win = (x >= from) && (x < from + len);
    endfunction

    // Band and period from finder time
    assign in_fast   = fin_ms_reg < cfg.fast_band_end_ms;
    assign in_medium = fin_ms_reg < cfg.medium_band_end_ms;

    always_comb
    begin
        priority if (in_fast)
            period = cfg.fast_period_ms;
        else if (in_medium)
            period = cfg.medium_period_ms;
        else
            period = cfg.slow_period_ms;
    end

    // Restoring remainder step
    assign rem_sh   = {rem_reg, dvd_reg[31]};
    assign rem_diff = rem_sh - {1'b0, period};
    assign rem_ge   = rem_sh >= {1'b0, period};

    // Pattern evaluation
    assign t = {21'd0, pat_ms_reg};

    always_comb
    begin
        pat_on    = 1'b0;
        pat_hz    = bts_pkg::DEFAULT_TONE;
        pat_clear = 1'b0;
        unique case (act_pat_reg)
            bts_pkg::PAT_NONE: ;
            bts_pkg::PAT_1:
            begin
                pat_on = win(t, 32'd0, 32'd180) || win(t, 32'd280, 32'd180) ||
                         win(t, 32'd560, 32'd260);
                priority if (win(t, 32'd0, 32'd180))
                    pat_hz = 12'd2200;
                else if (win(t, 32'd280, 32'd180))
                    pat_hz = 12'd2700;
                else
                    pat_hz = 12'd3300;
                pat_clear = t >= 32'd980;
            end
            bts_pkg::PAT_2:
            begin
                pat_on = win(t, 32'd0, 32'd160) || win(t, 32'd260, 32'd160) ||
                         win(t, 32'd520, 32'd320);
                priority if (win(t, 32'd0, 32'd160))
                    pat_hz = 12'd1800;
                else if (win(t, 32'd260, 32'd160))
                    pat_hz = 12'd2400;
                else
                    pat_hz = 12'd3200;
                pat_clear = t >= 32'd1000;
            end
            bts_pkg::PAT_3:
            begin
                pat_on    = win(t, 32'd0, 32'd420) || win(t, 32'd620, 32'd420);
                pat_hz    = 12'd850;
                pat_clear = t >= 32'd1250;
            end
            bts_pkg::PAT_4:
            begin
                pat_on = win(t, 32'd0, 32'd260) || win(t, 32'd420, 32'd260) ||
                         win(t, 32'd840, 32'd520);
                priority if (win(t, 32'd0, 32'd260))
                    pat_hz = 12'd2200;
                else if (win(t, 32'd420, 32'd260))
                    pat_hz = 12'd1500;
                else
                    pat_hz = 12'd900;
                pat_clear = t >= 32'd1600;
            end
            default:
                pat_clear = 1'b1;  // unknown pattern drops at once
        endcase
    end

    // Finder melody; a zero period leaves the elapsed time unwrapped
    assign ph = (period == 16'd0) ? fin_ms_reg : {16'd0, rem_reg};

    always_comb
    begin
        priority if (in_fast)
        begin
            fin_on = win(ph, 32'd0, 32'd320) || win(ph, 32'd520, 32'd320) ||
                     win(ph, 32'd1040, 32'd520);
            fin_hz = win(ph, 32'd1040, 32'd520) ? 12'd3000 : 12'd2200;
        end
        else if (in_medium)
        begin
            fin_on = win(ph, 32'd0, 32'd450) || win(ph, 32'd700, 32'd450);
            fin_hz = win(ph, 32'd700, 32'd450) ? 12'd2600 : 12'd1800;
        end
        else
        begin
            fin_on = win(ph, 32'd0, 32'd900);
            fin_hz = 12'd1800;
        end
    end

    assign finder_play = cfg.finder_enable && fin_act_reg &&
                         (pat_clear || (act_pat_reg == bts_pkg::PAT_NONE));
    assign eval_on = finder_play ? fin_on : pat_on;
    assign eval_hz = finder_play ? fin_hz : pat_hz;

    always_comb
    begin
        act_pat_next   = act_pat_reg;
        pat_ms_next    = pat_ms_reg;
        fin_act_next   = fin_act_reg;
        fin_ms_next    = fin_ms_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_on_next    = out_on_reg;
        out_hz_next    = out_hz_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (ctl.load)
        begin
            unique case (command)
                bts_pkg::CMD_TICK:
                begin
                    if (pat_ms_reg != bts_pkg::PAT_MS_MAX)
                        pat_ms_next = pat_ms_reg + 11'd1;
                    if (fin_ms_reg != 32'hFFFF_FFFF)
                        fin_ms_next = fin_ms_reg + 32'd1;
                end
                bts_pkg::CMD_START:
                begin
                    act_pat_next = pattern_number;
                    pat_ms_next  = 11'd0;
                end
                bts_pkg::CMD_FINDER:
                begin
                    fin_act_next = finder_on;
                    if (finder_on)
                        fin_ms_next = 32'd0;
                end
                default: ;
            endcase
        end

        if (ctl.div_start)
        begin
            dvd_next = fin_ms_reg;
            rem_next = 16'd0;
            cnt_next = bts_pkg::CNT_W'(bts_pkg::DIV_STEPS);
        end
        else if (ctl.div_step)
        begin
            dvd_next = {dvd_reg[30:0], 1'b0};
            rem_next = rem_ge ? rem_diff[15:0] : rem_sh[15:0];
            cnt_next = cnt_reg - bts_pkg::CNT_W'(1);
        end

        if (ctl.eval)
        begin
            out_valid_next = 1'b1;
            out_on_next    = eval_on;
            out_hz_next    = eval_hz;
            if (pat_clear)
                act_pat_next = bts_pkg::PAT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_pat_reg   <= bts_pkg::PAT_NONE;
            pat_ms_reg    <= 11'd0;
            fin_act_reg   <= 1'b0;
            fin_ms_reg    <= 32'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_pat_reg   <= act_pat_next;
            pat_ms_reg    <= pat_ms_next;
            fin_act_reg   <= fin_act_next;
            fin_ms_reg    <= fin_ms_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        out_on_reg <= out_on_next;
        out_hz_reg <= out_hz_next;
    end

    assign stat.div_done = (cnt_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign buzzer_on = out_on_reg;
    assign tone_hz   = out_hz_reg;

endmodule

### design/buzzer_tone_pattern_sequencer.sv
// Buzzer tone pattern sequencer: top level with APB register file.
// Depends on bts_pkg, bts_if, bts_ctrl and bts_dp.
// A command is accepted only while idle; the controller then loads the 32-step bit-serial
// remainder unit with finder time, divides it by the band period and evaluates the result.
// No new command is taken until the last is evaluated, which waits while a result is untaken.
// Reset (rst_n, asynchronous, active low) restores register defaults and clears state.
module buzzer_tone_pattern_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    bts_cmd_if.sink                      cmd,
    bts_res_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bts_pkg::ADDR_W-1:0]   paddr,
    input  logic [bts_pkg::DATA_W-1:0]   pwdata,
    output logic [bts_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    // Configuration registers
    logic        fin_en_reg, fin_en_next;
    logic [31:0] fast_end_reg, fast_end_next;
    logic [31:0] med_end_reg, med_end_next;
    logic [15:0] fast_per_reg, fast_per_next;
    logic [15:0] med_per_reg, med_per_next;
    logic [15:0] slow_per_reg, slow_per_next;

    logic        wr_en;
    logic [2:0]  reg_idx;

    bts_pkg::cfg_t  cfg;
    bts_pkg::ctrl_t ctl;
    bts_pkg::stat_t stat;

    // The port never stalls; a write lands on the access phase
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        fin_en_next   = fin_en_reg;
        fast_end_next = fast_end_reg;
        med_end_next  = med_end_reg;
        fast_per_next = fast_per_reg;
        med_per_next  = med_per_reg;
        slow_per_next = slow_per_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                bts_pkg::REG_FINDER_EN:  fin_en_next   = pwdata[0];
                bts_pkg::REG_FAST_END:   fast_end_next = pwdata;
                bts_pkg::REG_MEDIUM_END: med_end_next  = pwdata;
                bts_pkg::REG_FAST_PER:   fast_per_next = pwdata[15:0];
                bts_pkg::REG_MEDIUM_PER: med_per_next  = pwdata[15:0];
                bts_pkg::REG_SLOW_PER:   slow_per_next = pwdata[15:0];
                default: ;  // drop writes outside the register map
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_en_reg   <= 1'b1;
            fast_end_reg <= bts_pkg::RST_FAST_END;
            med_end_reg  <= bts_pkg::RST_MEDIUM_END;
            fast_per_reg <= bts_pkg::RST_FAST_PER;
            med_per_reg  <= bts_pkg::RST_MEDIUM_PER;
            slow_per_reg <= bts_pkg::RST_SLOW_PER;
        end
        else
        begin
            fin_en_reg   <= fin_en_next;
            fast_end_reg <= fast_end_next;
            med_end_reg  <= med_end_next;
            fast_per_reg <= fast_per_next;
            med_per_reg  <= med_per_next;
            slow_per_reg <= slow_per_next;
        end
    end

    // Read back; unmapped addresses read as zero
    always_comb
    begin
        unique case (reg_idx)
            bts_pkg::REG_FINDER_EN:  prdata = {31'd0, fin_en_reg};
            bts_pkg::REG_FAST_END:   prdata = fast_end_reg;
            bts_pkg::REG_MEDIUM_END: prdata = med_end_reg;
            bts_pkg::REG_FAST_PER:   prdata = {16'd0, fast_per_reg};
            bts_pkg::REG_MEDIUM_PER: prdata = {16'd0, med_per_reg};
            bts_pkg::REG_SLOW_PER:   prdata = {16'd0, slow_per_reg};
            default:                 prdata = '0;
        endcase
    end

    assign cfg.finder_enable      = fin_en_reg;
    assign cfg.fast_band_end_ms   = fast_end_reg;
    assign cfg.medium_band_end_ms = med_end_reg;
    assign cfg.fast_period_ms     = fast_per_reg;
    assign cfg.medium_period_ms   = med_per_reg;
    assign cfg.slow_period_ms     = slow_per_reg;

    // Controller: accept a command, run the remainder unit, then evaluate
    bts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Datapath: state, remainder unit, evaluation and the result register,
    // which holds a finished result while the next command is taken
    bts_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .ctl            (ctl),
        .stat           (stat),
        .command        (cmd.command),
        .pattern_number (cmd.pattern_number),
        .finder_on      (cmd.finder_on),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .buzzer_on      (rsp.buzzer_on),
        .tone_hz        (rsp.tone_hz)
    );

endmodule

### sim/bts_tone_checker.sv
// Result checker for the buzzer tone pattern sequencer: predicts each tone result and compares.
// Depends on bts_pkg and the channel interfaces in bts_if.
module bts_tone_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    bts_cmd_if                         cmd,
    bts_res_if                         rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [bts_pkg::ADDR_W-1:0] paddr,
    input  logic [bts_pkg::DATA_W-1:0] pwdata,
    output int                         fail_count,
    output int                         pending,
    output int                         checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        on;
        logic [11:0] hz;
    } tone_t;

    bts_pkg::cfg_t cfg;
    logic [7:0]    cur_pattern;
    logic [10:0]   pattern_ms;
    logic          finder_q;
    logic [31:0]   finder_ms;
    tone_t         tones_due[$];
    int            fails_n;
    int            checked_n;

    function automatic logic span(input logic [31:0] t, input logic [31:0] from,
                                  input logic [31:0] len);
        return (t >= from) && (t < from + len);
    endfunction

    function automatic tone_t locator_tone(input logic [31:0] ms);
        logic [31:0] per;
        logic [31:0] ph;
        tone_t       r;
        if (ms < cfg.fast_band_end_ms)
            per = 32'(cfg.fast_period_ms);
        else if (ms < cfg.medium_band_end_ms)
            per = 32'(cfg.medium_period_ms);
        else
            per = 32'(cfg.slow_period_ms);
        ph = (per != 0) ? ms % per : ms;
        if (ms < cfg.fast_band_end_ms)
        begin
            r.on = span(ph, 0, 320) || span(ph, 520, 320) || span(ph, 1040, 520);
            r.hz = span(ph, 1040, 520) ? 12'd3000 : 12'd2200;
        end
        else if (ms < cfg.medium_band_end_ms)
        begin
            r.on = span(ph, 0, 450) || span(ph, 700, 450);
            r.hz = span(ph, 700, 450) ? 12'd2600 : 12'd1800;
        end
        else
        begin
            r.on = span(ph, 0, 900);
            r.hz = 12'd1800;
        end
        return r;
    endfunction

    // Apply one command to the tracked state, then evaluate the buzzer
    function automatic tone_t next_tone(input logic [1:0] code, input logic [7:0] pat,
                                        input logic fon);
        logic [31:0] t;
        tone_t       r;
        case (code)
            bts_pkg::CMD_TICK:
            begin
                if (pattern_ms != bts_pkg::PAT_MS_MAX)
                    pattern_ms = pattern_ms + 11'd1;
                if (finder_ms != 32'hFFFF_FFFF)
                    finder_ms = finder_ms + 32'd1;
            end
            bts_pkg::CMD_START:
            begin
                cur_pattern = pat;
                pattern_ms  = '0;
            end
            bts_pkg::CMD_FINDER:
            begin
                finder_q = fon;
                if (fon)
                    finder_ms = '0;
            end
            default: ;
        endcase

        t    = 32'(pattern_ms);
        r.on = 1'b0;
        r.hz = bts_pkg::DEFAULT_TONE;
        case (cur_pattern)
            bts_pkg::PAT_NONE: ;
            bts_pkg::PAT_1:
            begin
                r.on = span(t, 0, 180) || span(t, 280, 180) || span(t, 560, 260);
                r.hz = span(t, 0, 180) ? 12'd2200 : span(t, 280, 180) ? 12'd2700 : 12'd3300;
                if (t >= 980)
                    cur_pattern = bts_pkg::PAT_NONE;
            end
            bts_pkg::PAT_2:
            begin
                r.on = span(t, 0, 160) || span(t, 260, 160) || span(t, 520, 320);
                r.hz = span(t, 0, 160) ? 12'd1800 : span(t, 260, 160) ? 12'd2400 : 12'd3200;
                if (t >= 1000)
                    cur_pattern = bts_pkg::PAT_NONE;
            end
            bts_pkg::PAT_3:
            begin
                r.on = span(t, 0, 420) || span(t, 620, 420);
                r.hz = 12'd850;
                if (t >= 1250)
                    cur_pattern = bts_pkg::PAT_NONE;
            end
            bts_pkg::PAT_4:
            begin
                r.on = span(t, 0, 260) || span(t, 420, 260) || span(t, 840, 520);
                r.hz = span(t, 0, 260) ? 12'd2200 : span(t, 420, 260) ? 12'd1500 : 12'd900;
                if (t >= 1600)
                    cur_pattern = bts_pkg::PAT_NONE;
            end
            default: cur_pattern = bts_pkg::PAT_NONE;
        endcase

        if (cfg.finder_enable && cur_pattern == bts_pkg::PAT_NONE && finder_q)
            r = locator_tone(finder_ms);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tone_t want;
        if (!rst_n)
        begin
            cfg.finder_enable      = 1'b1;
            cfg.fast_band_end_ms   = bts_pkg::RST_FAST_END;
            cfg.medium_band_end_ms = bts_pkg::RST_MEDIUM_END;
            cfg.fast_period_ms     = bts_pkg::RST_FAST_PER;
            cfg.medium_period_ms   = bts_pkg::RST_MEDIUM_PER;
            cfg.slow_period_ms     = bts_pkg::RST_SLOW_PER;
            cur_pattern = bts_pkg::PAT_NONE;
            pattern_ms  = '0;
            finder_q    = 1'b0;
            finder_ms   = '0;
            tones_due.delete();
            fails_n   = 0;
            checked_n = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[bts_pkg::ADDR_W-1:2])
                    bts_pkg::REG_FINDER_EN:  cfg.finder_enable      = pwdata[0];
                    bts_pkg::REG_FAST_END:   cfg.fast_band_end_ms   = pwdata;
                    bts_pkg::REG_MEDIUM_END: cfg.medium_band_end_ms = pwdata;
                    bts_pkg::REG_FAST_PER:   cfg.fast_period_ms     = pwdata[15:0];
                    bts_pkg::REG_MEDIUM_PER: cfg.medium_period_ms   = pwdata[15:0];
                    bts_pkg::REG_SLOW_PER:   cfg.slow_period_ms     = pwdata[15:0];
                    default: ;
                endcase
            end

            if (rsp.valid && rsp.ready)
            begin
                if (tones_due.size() == 0)
                begin
                    fails_n++;
                    $error("result arrived with no command awaiting it");
                end
                else
                begin
                    want = tones_due.pop_front();
                    checked_n++;
                    if (rsp.buzzer_on !== want.on)
                    begin
                        fails_n++;
                        $error("buzzer_on: expected %0d, got %0d", want.on, rsp.buzzer_on);
                    end
                    if (rsp.tone_hz !== want.hz)
                    begin
                        fails_n++;
                        $error("tone_hz: expected %0d, got %0d", want.hz, rsp.tone_hz);
                    end
                end
            end

            if (cmd.valid && cmd.ready)
                tones_due.push_back(next_tone(cmd.command, cmd.pattern_number, cmd.finder_on));
        end
        fail_count <= fails_n;
        pending    <= tones_due.size();
        checked    <= checked_n;
    end

endmodule

### sim/buzzer_tone_pattern_sequencer_tb.sv
// Top of the buzzer tone pattern sequencer testbench: clock, reset, stimulus and verdict.
// Depends on bts_pkg, bts_if, the sequencer RTL and bts_tone_checker.
module buzzer_tone_pattern_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Command code the block must take and simply evaluate
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Share of ordinary random commands per register setting (six settings)
    localparam int PHASE_ITEMS = 135;
    // Cycles to let pass after the last result: the block's latency plus margin
    localparam int SETTLE_CYCLES = 40;
    // Cycles with no transaction of any kind before the run is abandoned
    localparam int QUIET_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [bts_pkg::ADDR_W-1:0] paddr;
    logic [bts_pkg::DATA_W-1:0] pwdata;
    logic [bts_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    bts_cmd_if cmd_ch ();
    bts_res_if rsp_ch ();

    int fails;
    int pending_n;
    int checked_n;

    // Stimulus bookkeeping, used for the closing summary
    int n_items;
    int n_starts;
    int n_finder;
    int n_settings;
    int quiet_cycles;

    // Idling switches: source gaps, sink stalls, and whether either is allowed at all
    bit src_idle;
    bit sink_idle;
    bit idle_allowed;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    buzzer_tone_pattern_sequencer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bts_tone_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fails),
        .pending    (pending_n),
        .checked    (checked_n)
    );

    // Result sink: hold ready low in random bursts while stalls are enabled, else keep it high
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: abandon the run once nothing has moved on any port for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one command and return at the edge where it is accepted. A gap, when drawn,
    // drops valid first; otherwise valid stays high straight into the next transaction.
    task automatic send(input logic [1:0] code, input logic [7:0] pat, input logic fon);
        int gap;
        gap = (src_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.command        <= code;
        cmd_ch.pattern_number <= pat;
        cmd_ch.finder_on      <= fon;
        do @(posedge clk); while (!cmd_ch.ready);
        n_items++;
        if (code == bts_pkg::CMD_START)
            n_starts++;
        if (code == bts_pkg::CMD_FINDER)
            n_finder++;
    endtask

    // Drop valid, wait until every expected result is in, then let the block settle
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_n != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Rewrite the whole register file, only ever with the block idle
    task automatic set_regs(input logic en, input logic [31:0] fast_end,
                            input logic [31:0] medium_end, input logic [15:0] fast_per,
                            input logic [15:0] medium_per, input logic [15:0] slow_per);
        drain();
        write_reg(bts_pkg::REG_FINDER_EN, {31'd0, en});
        write_reg(bts_pkg::REG_FAST_END, fast_end);
        write_reg(bts_pkg::REG_MEDIUM_END, medium_end);
        write_reg(bts_pkg::REG_FAST_PER, {16'd0, fast_per});
        write_reg(bts_pkg::REG_MEDIUM_PER, {16'd0, medium_per});
        write_reg(bts_pkg::REG_SLOW_PER, {16'd0, slow_per});
        n_settings++;
    endtask

    // Mostly ticks with random don't-care fields; now and then a finder switch, an unused
    // command or a start of an arbitrary pattern byte
    task automatic tick_run(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 39);
            if (pick == 0)
                send(bts_pkg::CMD_FINDER, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
            else if (pick == 1)
                send(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick == 2)
                send(bts_pkg::CMD_START, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
            else
                send(bts_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        end
    endtask

    // Length of a tick run, kept inside what is left of the phase budget
    function automatic int run_len(input int most, input int room);
        int n;
        n = int'($urandom_range(1, most));
        return (n < room) ? n : room;
    endfunction

    // Random sequences: mostly a valid pattern start followed by ticks, plus finder
    // switches, stray pattern bytes, unused commands and bare tick runs
    task automatic random_phase(input int budget);
        int first;
        int kind;
        int room;
        first = n_items;
        while (n_items - first < budget)
        begin
            room = budget - (n_items - first);
            if (idle_allowed && $urandom_range(0, 2) == 0)
            begin
                src_idle  = $urandom_range(0, 1);
                sink_idle = $urandom_range(0, 1);
            end
            kind = $urandom_range(0, 15);
            if (kind < 9)
            begin
                send(bts_pkg::CMD_START, 8'($urandom_range(bts_pkg::PAT_1, bts_pkg::PAT_4)),
                     1'($urandom_range(0, 1)));
                tick_run(run_len(150, room - 1));
            end
            else if (kind < 12)
            begin
                send(bts_pkg::CMD_FINDER, 8'($urandom_range(0, 255)),
                     $urandom_range(0, 3) != 0);
                tick_run(run_len(150, room - 1));
            end
            else if (kind == 12)
            begin
                send(bts_pkg::CMD_START, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
                tick_run(run_len(20, room - 1));
            end
            else if (kind == 13)
                send(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                tick_run(run_len(200, room));
        end
    endtask

    initial
    begin
        // Every input known from the start; reset applied at the start, once only
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.command        <= bts_pkg::CMD_TICK;
        cmd_ch.pattern_number <= bts_pkg::PAT_NONE;
        cmd_ch.finder_on      <= 1'b0;
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        idle_allowed = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Wide fast band with a long period
        set_regs(1'b1, 32'd5000, 32'd9000, 16'd1600, 16'd1200, 16'd1000);

        // Directed: each pattern, stop, unknown and extreme pattern bytes, the unused
        // command, finder on and off
        send(bts_pkg::CMD_FINDER, bts_pkg::PAT_NONE, 1'b1);
        send(bts_pkg::CMD_TICK, bts_pkg::PAT_NONE, 1'b0);
        send(bts_pkg::CMD_START, bts_pkg::PAT_1, 1'b0);
        send(bts_pkg::CMD_TICK, bts_pkg::PAT_NONE, 1'b0);
        send(bts_pkg::CMD_START, bts_pkg::PAT_2, 1'b1);
        send(bts_pkg::CMD_START, bts_pkg::PAT_3, 1'b0);
        send(bts_pkg::CMD_START, bts_pkg::PAT_4, 1'b0);
        send(bts_pkg::CMD_TICK, 8'hFF, 1'b1);
        send(bts_pkg::CMD_START, 8'd5, 1'b0);
        send(bts_pkg::CMD_START, 8'hFF, 1'b1);
        send(bts_pkg::CMD_START, bts_pkg::PAT_1, 1'b0);
        send(bts_pkg::CMD_START, bts_pkg::PAT_NONE, 1'b0);
        send(CMD_UNUSED, 8'hFF, 1'b1);
        send(bts_pkg::CMD_FINDER, 8'hFF, 1'b0);
        send(bts_pkg::CMD_TICK, 8'hFF, 1'b1);
        send(bts_pkg::CMD_START, 8'h80, 1'b1);
        send(bts_pkg::CMD_FINDER, 8'h7F, 1'b1);
        send(bts_pkg::CMD_TICK, bts_pkg::PAT_NONE, 1'b0);
        random_phase(PHASE_ITEMS);

        // Pause the source until every result is back, then go again with the same setting
        drain();
        random_phase(PHASE_ITEMS / 4);

        // Slow band from the start, zero periods elsewhere, longest slow period
        set_regs(1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 16'd65535);
        random_phase(PHASE_ITEMS);

        // Fast band for ever with a one-millisecond period: the first note never ends
        set_regs(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'd65535, 16'd1);
        random_phase(PHASE_ITEMS);

        // Medium band for ever, zero medium period: phase is the elapsed time itself
        set_regs(1'b1, 32'd0, 32'hFFFF_FFFF, 16'd65535, 16'd0, 16'd0);
        random_phase(PHASE_ITEMS);

        // Finder melody disabled, arbitrary band settings
        set_regs(1'b0, $urandom, $urandom, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        random_phase(PHASE_ITEMS);

        // Last part: random but reachable bands, no idling on either side
        set_regs(1'b1, $urandom_range(0, 3000), $urandom_range(0, 6000),
                 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                 16'($urandom_range(0, 2000)));
        idle_allowed = 1'b0;
        src_idle     = 1'b0;
        sink_idle    = 1'b0;
        random_phase(PHASE_ITEMS);

        drain();
        $display("Covered %0d commands: %0d pattern starts, %0d finder switches",
                 n_items, n_starts, n_finder);
        $display("Register settings: %0d, results compared: %0d, mismatches: %0d",
                 n_settings, checked_n, fails);
        if (fails == 0 && pending_n == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
